// File: rtl/lma_pkg.sv
package lma_pkg;

	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int HEAD_W       = $clog2(MAX_WINDOW);
	localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W        = SAMPLE_WIDTH + HEAD_W;
	localparam int WIN_W        = 7;
	localparam int DATA_W       = 32;
	localparam int FIFO_DEPTH   = 2;

	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

	// Register word indexes on the configuration port.
	localparam logic REG_WINDOW = 1'b0;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           restart;
	} item_t;

	typedef struct packed {
		logic [CNT_W-1:0] window;
		logic             clear;
	} cfg_t;

	typedef struct packed {
		logic              busy;
		logic [CNT_W-1:0]  seen;
		logic [HEAD_W-1:0] head;
	} back_status_t;

endpackage

// File: rtl/lma_ram.sv
module lma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/lma_div.sv
module lma_div import lma_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic signed [SUM_W-1:0]        dividend,
	input  logic        [CNT_W-1:0]        divisor,
	output logic                           done,
	output logic signed [SAMPLE_WIDTH-1:0] quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [CNT_W-1:0]  rem_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  divisor_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;

	logic [CNT_W:0]   trial;
	logic [CNT_W:0]   diff;
	logic             ge;
	logic [SUM_W-1:0] magnitude;
	logic [SUM_W-1:0] signed_quo;

	// The partial remainder stays below the divisor, so it fits the divisor's width.
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	assign magnitude = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= magnitude;
			neg_q     <= dividend[SUM_W-1];
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign signed_quo = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
	assign quotient   = signed_quo[SAMPLE_WIDTH-1:0];
	assign done       = done_q;

endmodule

// File: rtl/lma_front.sv
module lma_front import lma_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	item_t             slot_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic              push;
	logic              pop;

	assign in_ready  = count_q != FCNT_W'(FIFO_DEPTH);
	assign out_valid = count_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

// File: rtl/lma_back.sv
module lma_back import lma_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  cfg_t                           cfg,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  item_t                          item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic                           full_window,
	output back_status_t                   status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LOAD,
		S_DIV,
		S_PUT
	} state_t;

	state_t                         state_q;
	logic        [HEAD_W-1:0]       head_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic        [CNT_W-1:0]        seen_q;
	logic signed [SAMPLE_WIDTH-1:0] last_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic signed [SAMPLE_WIDTH-1:0] res_q;
	logic                           full_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] average_q;
	logic                           full_window_q;

	logic        [HEAD_W-1:0]       head_eff;
	logic        [CNT_W-1:0]        head_inc;
	logic                           window_full;
	logic        [SAMPLE_WIDTH-1:0] ring_rdata;
	logic signed [SUM_W-1:0]        sub_val;
	logic signed [SUM_W-1:0]        add_val;
	logic                           div_start;
	logic                           div_done;
	logic signed [SAMPLE_WIDTH-1:0] div_quo;
	logic                           out_free;

	assign item_ready  = state_q == S_IDLE;
	assign head_eff    = (CNT_W'(head_q) >= cfg.window) ? '0 : head_q;
	assign head_inc    = CNT_W'(head_q) + CNT_W'(1);
	assign window_full = seen_q >= cfg.window;
	assign sub_val     = window_full ? SUM_W'($signed(ring_rdata)) : '0;
	assign add_val     = SUM_W'(sample_q);
	assign div_start   = (state_q == S_LOAD) && window_full;
	assign out_free    = !out_valid_q || result_ready;

	lma_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk  (clk),
		.we   (state_q == S_LOAD),
		.waddr(head_q),
		.wdata(sample_q),
		.re   (state_q == S_READ),
		.raddr(head_eff),
		.rdata(ring_rdata)
	);

	lma_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(sum_q),
		.divisor (cfg.window),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			sum_q         <= '0;
			seen_q        <= '0;
			last_q        <= '0;
			out_valid_q   <= 1'b0;
			sample_q      <= '0;
			res_q         <= '0;
			full_q        <= 1'b0;
			average_q     <= '0;
			full_window_q <= 1'b0;
		end else begin
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						sample_q <= item.sample;
						if (item.restart) begin
							head_q <= '0;
							sum_q  <= '0;
							seen_q <= '0;
							last_q <= '0;
						end
						state_q <= S_READ;
					end
				end
				S_READ: begin
					head_q  <= head_eff;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					full_q <= window_full;
					if (seen_q == '0) begin
						res_q <= '0;
					end else begin
						res_q <= last_q;
					end
					if (!window_full) begin
						seen_q <= seen_q + CNT_W'(1);
					end
					sum_q   <= sum_q - sub_val + add_val;
					head_q  <= (head_inc >= cfg.window) ? '0 : head_inc[HEAD_W-1:0];
					last_q  <= sample_q;
					state_q <= window_full ? S_DIV : S_PUT;
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= div_quo;
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						average_q     <= res_q;
						full_window_q <= full_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A window write begins a new series.
			if (cfg.clear) begin
				head_q <= '0;
				sum_q  <= '0;
				seen_q <= '0;
				last_q <= '0;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign average      = average_q;
	assign full_window  = full_window_q;
	assign status.busy  = state_q != S_IDLE;
	assign status.seen  = seen_q;
	assign status.head  = head_q;

endmodule

// File: rtl/lagged_moving_average.sv
// Lagged moving average of a Q24.8 sample stream, one result per sample.
// A full window's mean is formed by a 38-step restoring divider, which a partial
// window skips.
// One item is worked at a time; a two-entry input queue takes beats meanwhile.
// Reset clears the series state and sets the window to 3; the sample ring needs no clearing.
module lagged_moving_average import lma_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic        [2:0]              paddr,
	input  logic        [DATA_W-1:0]       pwdata,
	output logic        [DATA_W-1:0]       prdata,
	output logic                           pready,
	input  logic                           sample_valid,
	output logic                           sample_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           restart,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic signed [SAMPLE_WIDTH-1:0] average,
	output logic                           full_window
);

	logic [WIN_W-1:0] window_q;
	logic             cfg_write;
	cfg_t             cfg;
	item_t            in_item;
	item_t            q_item;
	logic             q_valid;
	logic             q_ready;
	back_status_t     st;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_WINDOW);
	assign prdata    = (paddr[2] == REG_WINDOW) ? DATA_W'(window_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_write) begin
			window_q <= pwdata[WIN_W-1:0];
		end
	end

	// Out-of-range windows are clamped into 1 to MAX_WINDOW.
	always_comb begin
		if (window_q == '0) begin
			cfg.window = CNT_W'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			cfg.window = CNT_W'(MAX_WINDOW);
		end else begin
			cfg.window = CNT_W'(window_q);
		end
		cfg.clear = cfg_write;
	end

	assign in_item.sample  = sample;
	assign in_item.restart = restart;

	lma_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample_valid),
		.in_ready (sample_ready),
		.in_item  (in_item),
		.out_valid(q_valid),
		.out_ready(q_ready),
		.out_item (q_item)
	);

	lma_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.item_valid  (q_valid),
		.item_ready  (q_ready),
		.item        (q_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.average     (average),
		.full_window (full_window),
		.status      (st)
	);

	a_seen_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		st.seen <= cfg.window)
		else $error("seen count exceeds the window");

	a_head_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(st.head) < cfg.window)
		else $error("ring head outside the window");

	a_result_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(st.busy))
		else $error("result appeared without the back end working");

endmodule

// File: test/lma_mean_checker.sv
module lma_mean_checker import lma_pkg::*; (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic        [2:0]              paddr,
	input  logic        [DATA_W-1:0]       pwdata,
	input  logic                           pready,
	input  logic                           sample_valid,
	input  logic                           sample_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                           restart,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] average,
	input  logic                           full_window,
	output int                             fail_count,
	output int                             pending_count,
	output int                             result_count,
	output int                             full_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [SAMPLE_WIDTH-1:0] average;
		logic                           full_window;
	} lagged_mean_t;

	lagged_mean_t pending_means[$];

	// Shadow of the block's series state and window register.
	logic signed [SAMPLE_WIDTH-1:0] past_samples[MAX_WINDOW];
	int unsigned                    oldest_slot;
	int unsigned                    series_len;
	longint                         window_total;
	logic signed [SAMPLE_WIDTH-1:0] previous_sample;
	logic        [WIN_W-1:0]        window_days;

	function automatic void restart_series();
		oldest_slot     = 0;
		series_len      = 0;
		window_total    = 0;
		previous_sample = '0;
	endfunction

	function automatic lagged_mean_t next_lagged_mean(
		input logic signed [SAMPLE_WIDTH-1:0] value,
		input logic                           first
	);
		lagged_mean_t mean;
		int unsigned  span;
		longint       quotient;
		if (window_days == 0) begin
			span = 1;
		end else if (window_days > MAX_WINDOW) begin
			span = MAX_WINDOW;
		end else begin
			span = 32'(window_days);
		end
		if (first) begin
			restart_series();
		end
		if (oldest_slot >= span) begin
			oldest_slot = 0;
		end
		if (series_len == 0) begin
			mean.average     = '0;
			mean.full_window = 1'b0;
		end else if (series_len < span) begin
			mean.average     = previous_sample;
			mean.full_window = 1'b0;
		end else begin
			// Signed division truncates toward zero, as the block's mean does.
			quotient         = window_total / longint'(span);
			mean.average     = quotient[SAMPLE_WIDTH-1:0];
			mean.full_window = 1'b1;
		end
		if (series_len >= span) begin
			window_total -= longint'(past_samples[oldest_slot[HEAD_W-1:0]]);
		end else begin
			series_len++;
		end
		window_total += longint'(value);
		past_samples[oldest_slot[HEAD_W-1:0]] = value;
		oldest_slot++;
		if (oldest_slot >= span) begin
			oldest_slot = 0;
		end
		previous_sample = value;
		return mean;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lagged_mean_t want;
		if (!arst_n) begin
			window_days = WINDOW_RESET;
			restart_series();
			pending_means.delete();
			fail_count    <= 0;
			pending_count <= 0;
			result_count  <= 0;
			full_count    <= 0;
		end else begin
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_WINDOW) begin
				window_days = pwdata[WIN_W-1:0];
				restart_series();
			end
			if (result_valid && result_ready) begin
				result_count <= result_count + 1;
				if (full_window) begin
					full_count <= full_count + 1;
				end
				if (pending_means.size() == 0) begin
					$error("result beat with no sample waiting: average %0d, full_window %0b",
						average, full_window);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_means.pop_front();
					if (average !== want.average || full_window !== want.full_window) begin
						fail_count <= fail_count + 1;
					end
					if (average !== want.average) begin
						$error("average mismatch: expected %0d, actual %0d",
							want.average, average);
					end
					if (full_window !== want.full_window) begin
						$error("full_window mismatch: expected %0b, actual %0b",
							want.full_window, full_window);
					end
				end
			end
			if (sample_valid && sample_ready) begin
				pending_means.push_back(next_lagged_mean(sample, restart));
			end
			pending_count <= pending_means.size();
		end
	end

endmodule

// File: test/tb_top.sv
module tb_top import lma_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 60;
	localparam int DRAIN_CYCLES  = 100;
	localparam int HOLD_CYCLES   = 600;
	localparam int SEGMENTS      = 12;
	localparam int SEGMENT_BEATS = 160;

	localparam logic [2:0] ADDR_WINDOW   = {REG_WINDOW, 2'b00};
	// One word past the only register; writes there must be ignored.
	localparam logic [2:0] ADDR_UNMAPPED = 3'(4);

	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic        [2:0]              paddr        = '0;
	logic        [DATA_W-1:0]       pwdata       = '0;
	logic        [DATA_W-1:0]       prdata;
	logic                           pready;
	logic                           sample_valid = 1'b0;
	logic                           sample_ready;
	logic signed [SAMPLE_WIDTH-1:0] sample       = '0;
	logic                           restart      = 1'b0;
	logic                           result_valid;
	logic                           result_ready = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0] average;
	logic                           full_window;

	int fail_count;
	int pending_count;
	int result_count;
	int full_count;

	int send_idle_pct = 28;
	int recv_idle_pct = 53;
	bit hold_request  = 1'b0;
	int beats_sent    = 0;
	int settings_used = 1;
	logic signed [SAMPLE_WIDTH-1:0] index_level = 32'sd25600;

	always #6 clk = ~clk;

	lagged_moving_average dut (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.sample_valid, .sample_ready, .sample, .restart,
		.result_valid, .result_ready, .average, .full_window
	);

	lma_mean_checker mean_check (
		.clk, .arst_n,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.sample_valid, .sample_ready, .sample, .restart,
		.result_valid, .result_ready, .average, .full_window,
		.fail_count, .pending_count, .result_count, .full_count
	);

	// Result side: random stalls, or one long hold-off when asked for.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$error("run did not finish within %0d cycles, %0d results outstanding",
			CYCLE_LIMIT, pending_count);
		$display("Test completed with failures");
		$finish;
	end

	task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value, input logic first);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= value;
		restart      <= first;
		do @(posedge clk); while (!sample_ready);
		beats_sent++;
	endtask

	// Waits until every result is back and the block is quiet, then does one write.
	task automatic write_register(input logic [2:0] addr, input logic [DATA_W-1:0] data);
		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_WINDOW) begin
			settings_used++;
		end
	endtask

	function automatic logic signed [SAMPLE_WIDTH-1:0] draw_sample(input bit extreme, input int pos);
		int pick;
		pick = $urandom_range(99);
		if (extreme && pick < 90) begin
			// Long runs at one rail push the running sum to its limits.
			return ((pos / 70) % 2) ? SAMPLE_MIN : SAMPLE_MAX;
		end
		if (pick < 6) begin
			return SAMPLE_MAX;
		end else if (pick < 12) begin
			return SAMPLE_MIN;
		end else if (pick < 16) begin
			return $urandom_range(1) ? '0 : '1;
		end else if (pick < 45) begin
			return $urandom();
		end
		index_level = index_level + $signed(32'($urandom_range(512))) - 32'sd256;
		return index_level;
	endfunction

	initial begin
		int          seg;
		int          beat;
		logic [WIN_W-1:0] span;
		bit          extreme;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset window of three: first sample, partial window, then full windows.
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample('1, 1'b0);
		send_sample('0, 1'b0);
		send_sample(32'sd256, 1'b0);
		send_sample(32'sd5, 1'b1);
		send_sample(32'sd7, 1'b0);

		write_register(ADDR_WINDOW, 32'd1);
		send_sample(-32'sd9, 1'b0);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);

		// A window of zero behaves as one.
		write_register(ADDR_WINDOW, 32'd0);
		send_sample(32'sd11, 1'b0);
		send_sample(-32'sd11, 1'b0);

		// The unmapped write must neither change the window nor restart the series.
		write_register(ADDR_UNMAPPED, 32'd5);
		send_sample(32'sd4, 1'b0);
		send_sample(32'sd6, 1'b1);

		// Above the maximum the window saturates.
		write_register(ADDR_WINDOW, 32'hFFFF_FFFF);
		send_sample(32'sd100, 1'b0);
		send_sample(32'sd200, 1'b0);

		// Negative means must truncate toward zero.
		write_register(ADDR_WINDOW, 32'd2);
		send_sample(-32'sd3, 1'b0);
		send_sample(-32'sd4, 1'b0);
		send_sample(32'sd1, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			if (seg < 4) begin
				send_idle_pct = 28;
				recv_idle_pct = 53;
			end else if (seg < 8) begin
				send_idle_pct = 53;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			extreme = 1'b0;
			case (seg % 4)
				0: span = WIN_W'($urandom_range(1, 8));
				1: begin
					span    = (seg % 8 == 1) ? WIN_W'(MAX_WINDOW) :
						WIN_W'($urandom_range(MAX_WINDOW + 1, (1 << WIN_W) - 1));
					extreme = 1'b1;
				end
				2: span = WIN_W'($urandom_range(1, MAX_WINDOW));
				default: span = WIN_W'($urandom_range(2, 16));
			endcase
			// Upper data bits are random; only the low bits hold the window.
			write_register(ADDR_WINDOW, ($urandom() & ~32'(7'h7F)) | 32'(span));
			if (seg == 2 || seg == 9) begin
				hold_request = 1'b1;
			end
			for (beat = 0; beat < SEGMENT_BEATS; beat++) begin
				send_sample(draw_sample(extreme, beat), $urandom_range(99) < 2);
			end
		end

		sample_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d sample beats across %0d window settings, with stalls on both sides.",
			beats_sent, settings_used);
		$display("%0d results checked, %0d of them over a full window.", result_count, full_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// File: filelist.f
rtl/lma_pkg.sv
rtl/lma_ram.sv
rtl/lma_div.sv
rtl/lma_front.sv
rtl/lma_back.sv
rtl/lagged_moving_average.sv
test/lma_mean_checker.sv
test/tb_top.sv
